// ----- design/dpfd_pkg.sv -----
// dual protocol frame demux: shared package
// codes, widths and the result record used by the top level
`default_nettype none

package dpfd_pkg;

    localparam int LOOK_DEPTH   = 6;
    localparam int COUNT_W      = 3;
    localparam int REMAIN_W     = 17;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // frame length overheads
    localparam logic [REMAIN_W-1:0] LEGACY_OVERHEAD = 17'd5;
    localparam logic [REMAIN_W-1:0] SENSOR_OVERHEAD = 17'd10;

    localparam logic [COUNT_W-1:0] LEGACY_HDR_BYTES = 3'd4;
    localparam logic [COUNT_W-1:0] SENSOR_HDR_BYTES = 3'd6;
    localparam logic [COUNT_W-1:0] MIN_JUDGE_BYTES  = 3'd2;

    // byte kinds
    localparam logic [2:0] KIND_LEGACY      = 3'd0;
    localparam logic [2:0] KIND_SENSOR      = 3'd1;
    localparam logic [2:0] KIND_DROP_NOHDR  = 3'd2;
    localparam logic [2:0] KIND_DROP_LEGLEN = 3'd3;
    localparam logic [2:0] KIND_DROP_SENHDR = 3'd4;

    // frame phase
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_LEGACY = 2'd1;
    localparam logic [1:0] PH_SENSOR = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LEG_HEAD_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEG_HEAD_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEG_MAX_PAYLOAD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEN_MAGIC_FIRST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEN_MAGIC_SECOND = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SEN_VERSION     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SEN_MAX_PAYLOAD = 3'd6;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       first;
        logic       last;
        logic       run_end;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dual_protocol_frame_demux_unit.sv -----
// dual protocol frame demux: top level with lookahead, scan sequencer and output register
// depends on dpfd_pkg
`default_nettype none

// a byte of a frame being streamed comes out in the cycle after its transfer,
// and the next byte may follow in the next cycle unless the output is stalled.
// a byte taken while hunting for a header holds in_stall high through the judge and finish states,
// and while the six-byte lookahead is scanned again, one judge, dropped or emitted byte
// per cycle through the single scan sequencer, and longer while the output is stalled.
// reset: all control state, lookahead count and registers return to defaults; no clearing pass
module dual_protocol_frame_demux_unit
    import dpfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  data_byte,
    output logic [2:0]                  byte_kind,
    output logic                        frame_first,
    output logic                        frame_last,
    output logic                        run_end,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [7:0]  leg_first_reg;
    logic [7:0]  leg_second_reg;
    logic [7:0]  leg_max_reg;
    logic [7:0]  sen_first_reg;
    logic [7:0]  sen_second_reg;
    logic [7:0]  sen_version_reg;
    logic [15:0] sen_max_reg;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          emit_phase_reg, emit_phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  emit_left_reg, emit_left_next;
    logic                emit_first_reg, emit_first_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic [7:0]          look_reg [LOOK_DEPTH];
    logic [7:0]          look_next [LOOK_DEPTH];
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;

    logic        out_free;
    logic        can_push;
    logic        push;
    result_t     push_res;
    logic        do_shift;
    logic        streaming;
    logic        in_xfer;
    logic [15:0] sen_len;
    logic [REMAIN_W-1:0] leg_total;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign can_push  = !pend_valid_reg || out_free;
    assign streaming = (phase_reg == PH_LEGACY) || (phase_reg == PH_SENSOR);
    assign in_stall  = (state_reg != ST_IDLE) || (streaming && !out_free);
    assign in_xfer   = in_valid && !in_stall;
    assign sen_len   = {look_reg[5], look_reg[4]};
    assign leg_total = {9'd0, look_reg[3]} + LEGACY_OVERHEAD;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        emit_phase_next = emit_phase_reg;
        count_next      = count_reg;
        emit_left_next  = emit_left_reg;
        emit_first_next = emit_first_reg;
        remain_next     = remain_reg;
        look_next       = look_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_free;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_res        = '0;
        do_shift        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (streaming)
                    begin
                        out_next.data    = rx_byte;
                        out_next.kind    = (phase_reg == PH_SENSOR) ? KIND_SENSOR : KIND_LEGACY;
                        out_next.first   = 1'b0;
                        out_next.last    = (remain_reg <= 17'd1);
                        out_next.run_end = 1'b1;
                        out_valid_next   = 1'b1;
                        if (remain_reg <= 17'd1)
                        begin
                            remain_next = '0;
                            phase_next  = PH_HUNT;
                        end
                        else
                        begin
                            remain_next = remain_reg - 17'd1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        if (count_reg < COUNT_W'(LOOK_DEPTH))
                        begin
                            look_next[count_reg] = rx_byte;
                            count_next = count_reg + 3'd1;
                        end
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (count_reg < MIN_JUDGE_BYTES)
                begin
                    state_next = ST_FINISH;
                end
                else if (look_reg[0] == leg_first_reg && look_reg[1] == leg_second_reg)
                begin
                    if (count_reg < LEGACY_HDR_BYTES)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (look_reg[3] > leg_max_reg)
                    begin
                        if (can_push)
                        begin
                            push          = 1'b1;
                            push_res.data = look_reg[0];
                            push_res.kind = KIND_DROP_LEGLEN;
                            do_shift      = 1'b1;
                        end
                    end
                    else
                    begin
                        remain_next     = leg_total;
                        // a zero-length frame ends inside a full lookahead
                        emit_left_next  = (REMAIN_W'(count_reg) < leg_total) ?
                                          count_reg : leg_total[COUNT_W-1:0];
                        emit_first_next = 1'b1;
                        emit_phase_next = PH_LEGACY;
                        state_next      = ST_EMIT;
                    end
                end
                else if (look_reg[0] == sen_first_reg && look_reg[1] == sen_second_reg)
                begin
                    if (count_reg < SENSOR_HDR_BYTES)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (look_reg[2] != sen_version_reg || sen_len > sen_max_reg)
                    begin
                        if (can_push)
                        begin
                            push          = 1'b1;
                            push_res.data = look_reg[0];
                            push_res.kind = KIND_DROP_SENHDR;
                            do_shift      = 1'b1;
                        end
                    end
                    else
                    begin
                        remain_next     = {1'b0, sen_len} + SENSOR_OVERHEAD;
                        emit_left_next  = count_reg;
                        emit_first_next = 1'b1;
                        emit_phase_next = PH_SENSOR;
                        state_next      = ST_EMIT;
                    end
                end
                else if (can_push)
                begin
                    push          = 1'b1;
                    push_res.data = look_reg[0];
                    push_res.kind = KIND_DROP_NOHDR;
                    do_shift      = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (can_push)
                begin
                    push            = 1'b1;
                    push_res.data   = look_reg[0];
                    push_res.kind   = (emit_phase_reg == PH_SENSOR) ? KIND_SENSOR : KIND_LEGACY;
                    push_res.first  = emit_first_reg;
                    push_res.last   = (remain_reg == 17'd1);
                    do_shift        = 1'b1;
                    emit_first_next = 1'b0;
                    remain_next     = remain_reg - 17'd1;
                    emit_left_next  = emit_left_reg - 3'd1;
                    if (emit_left_reg == 3'd1)
                    begin
                        if (remain_reg == 17'd1)
                        begin
                            // frame ended inside the lookahead: scan the rest
                            phase_next = PH_HUNT;
                            state_next = ST_EVAL;
                        end
                        else
                        begin
                            phase_next = emit_phase_reg;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next         = pend_reg;
                    out_next.run_end = 1'b1;
                    out_valid_next   = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // newest result waits in the pending slot until its run_end is known
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end

        if (do_shift)
        begin
            for (int i = 0; i < LOOK_DEPTH - 1; i++)
            begin
                look_next[i] = look_reg[i+1];
            end
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_HUNT;
            emit_phase_reg <= PH_HUNT;
            count_reg      <= '0;
            emit_left_reg  <= '0;
            emit_first_reg <= 1'b0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            emit_phase_reg <= emit_phase_next;
            count_reg      <= count_next;
            emit_left_reg  <= emit_left_next;
            emit_first_reg <= emit_first_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        look_reg <= look_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_first_reg   <= 8'h55;
            leg_second_reg  <= 8'hAA;
            leg_max_reg     <= 8'd64;
            sen_first_reg   <= 8'hA5;
            sen_second_reg  <= 8'h5A;
            sen_version_reg <= 8'd1;
            sen_max_reg     <= 16'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEG_HEAD_FIRST:   leg_first_reg   <= cfg_data[7:0];
                REG_LEG_HEAD_SECOND:  leg_second_reg  <= cfg_data[7:0];
                REG_LEG_MAX_PAYLOAD:  leg_max_reg     <= cfg_data[7:0];
                REG_SEN_MAGIC_FIRST:  sen_first_reg   <= cfg_data[7:0];
                REG_SEN_MAGIC_SECOND: sen_second_reg  <= cfg_data[7:0];
                REG_SEN_VERSION:      sen_version_reg <= cfg_data[7:0];
                REG_SEN_MAX_PAYLOAD:  sen_max_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = out_reg.data;
    assign byte_kind   = out_reg.kind;
    assign frame_first = out_reg.first;
    assign frame_last  = out_reg.last;
    assign run_end     = out_reg.run_end;

    a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (count_reg < COUNT_W'(LOOK_DEPTH)))
        else $error("lookahead full while idle");

    a_stream_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && phase_reg != PH_HUNT) |-> (remain_reg != '0))
        else $error("streaming with no bytes remaining");

    a_marks_on_frames: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.first || out_reg.last)) |->
        (out_reg.kind == KIND_LEGACY || out_reg.kind == KIND_SENSOR))
        else $error("frame mark on a dropped byte");

endmodule

`default_nettype wire

// ----- sim/dual_protocol_frame_demux_unit_tb.sv -----
// testbench for dual_protocol_frame_demux_unit: drives received bytes and register writes,
// predicts the tagged byte stream in-bench and compares each output transfer
// depends on dpfd_pkg and the dual_protocol_frame_demux_unit rtl
`default_nettype none

module dual_protocol_frame_demux_unit_tb;
    import dpfd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam int SCAN_SLACK   = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 55;
    localparam int NUM_PHASES   = 5;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [15:0]            val;
        logic                   typed;
        result_t                exp;
    } script_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             data_byte;
    logic [2:0]             byte_kind;
    logic                   frame_first;
    logic                   frame_last;
    logic                   run_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers
    logic [7:0]  leg_first;
    logic [7:0]  leg_second;
    logic [7:0]  leg_max;
    logic [7:0]  sen_first;
    logic [7:0]  sen_second;
    logic [7:0]  sen_ver;
    logic [15:0] sen_max;

    // predictor copy of the block state
    logic [7:0]          la_buf [LOOK_DEPTH];
    int                  la_cnt;
    logic [1:0]          la_phase;
    logic [REMAIN_W-1:0] remain;

    result_t     step_out [$];
    result_t     due_bytes [$];
    script_row_t script [$];

    int fail_count;
    int idle_pct;
    int quiet_cycles;
    bit hold_req;

    dual_protocol_frame_demux_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .byte_kind   (byte_kind),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .run_end     (run_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 30)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            log_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
        end
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            REG_LEG_HEAD_FIRST:   leg_first  = val[7:0];
            REG_LEG_HEAD_SECOND:  leg_second = val[7:0];
            REG_LEG_MAX_PAYLOAD:  leg_max    = val[7:0];
            REG_SEN_MAGIC_FIRST:  sen_first  = val[7:0];
            REG_SEN_MAGIC_SECOND: sen_second = val[7:0];
            REG_SEN_VERSION:      sen_ver    = val[7:0];
            REG_SEN_MAX_PAYLOAD:  sen_max    = val;
            default: ;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] b, input logic [2:0] kind,
                                 input logic first, input logic last);
        result_t r;
        r.data    = b;
        r.kind    = kind;
        r.first   = first;
        r.last    = last;
        r.run_end = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void shift_la(input int k);
        int i;
        if (k >= la_cnt)
        begin
            la_cnt = 0;
        end
        else
        begin
            for (i = 0; i < la_cnt - k; i++)
            begin
                la_buf[i] = la_buf[i + k];
            end
            la_cnt -= k;
        end
    endfunction

    function automatic void drop_head(input logic [2:0] kind);
        emit(la_buf[0], kind, 1'b0, 1'b0);
        shift_la(1);
    endfunction

    // judge the lookahead until it needs more bytes or a frame is left streaming
    function automatic void rescan_lookahead();
        logic [REMAIN_W-1:0] total;
        logic [15:0]         len;
        int                  take;
        int                  i;
        bit                  done;
        done = 1'b0;
        while (!done)
        begin
            if (la_cnt < 2)
            begin
                done = 1'b1;
            end
            else if (la_buf[0] == leg_first && la_buf[1] == leg_second)
            begin
                if (la_cnt < 4)
                begin
                    done = 1'b1;
                end
                else if (la_buf[3] > leg_max)
                begin
                    drop_head(KIND_DROP_LEGLEN);
                end
                else
                begin
                    total = LEGACY_OVERHEAD + la_buf[3];
                    take = (la_cnt < total) ? la_cnt : int'(total);
                    for (i = 0; i < take; i++)
                    begin
                        emit(la_buf[i], KIND_LEGACY, i == 0, i + 1 == total);
                    end
                    shift_la(take);
                    // a short frame may finish inside the lookahead; keep scanning then
                    if (take < total)
                    begin
                        la_phase = PH_LEGACY;
                        remain = total - REMAIN_W'(take);
                        done = 1'b1;
                    end
                end
            end
            else if (la_buf[0] == sen_first && la_buf[1] == sen_second)
            begin
                if (la_cnt < 6)
                begin
                    done = 1'b1;
                end
                else
                begin
                    len = {la_buf[5], la_buf[4]};
                    if (la_buf[2] != sen_ver || len > sen_max)
                    begin
                        drop_head(KIND_DROP_SENHDR);
                    end
                    else
                    begin
                        total = SENSOR_OVERHEAD + len;
                        for (i = 0; i < la_cnt; i++)
                        begin
                            emit(la_buf[i], KIND_SENSOR, i == 0, 1'b0);
                        end
                        remain = total - REMAIN_W'(la_cnt);
                        la_cnt = 0;
                        la_phase = PH_SENSOR;
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                drop_head(KIND_DROP_NOHDR);
            end
        end
    endfunction

    function automatic void demux_rx_byte(input logic [7:0] rx);
        bit last;
        step_out.delete();
        if (la_phase == PH_LEGACY || la_phase == PH_SENSOR)
        begin
            last = (remain <= 1);
            emit(rx, (la_phase == PH_LEGACY) ? KIND_LEGACY : KIND_SENSOR, 1'b0, last);
            if (last)
            begin
                remain = '0;
                la_phase = PH_HUNT;
            end
            else
            begin
                remain--;
            end
        end
        else
        begin
            la_phase = PH_HUNT;
            if (la_cnt < LOOK_DEPTH)
            begin
                la_buf[la_cnt] = rx;
                la_cnt++;
            end
            rescan_lookahead();
        end
        if (step_out.size() > 0)
        begin
            step_out[step_out.size() - 1].run_end = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (in_stall);
        demux_rx_byte(b);
        if (typed)
        begin
            due_bytes.push_back(want);
        end
        else
        begin
            foreach (step_out[i])
            begin
                due_bytes.push_back(step_out[i]);
            end
        end
    endtask

    // sender goes quiet until every predicted byte is out and the scan has settled
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SCAN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        apply_cfg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_phase(input int p);
        logic [7:0]  lh1;
        logic [7:0]  lh2;
        logic [7:0]  lmax;
        logic [7:0]  sm1;
        logic [7:0]  sm2;
        logic [7:0]  sver;
        logic [15:0] smax;
        lh1  = 8'($urandom_range(0, 255));
        lh2  = 8'($urandom_range(0, 255));
        sm1  = 8'($urandom_range(0, 255));
        sm2  = 8'($urandom_range(0, 255));
        sver = 8'($urandom_range(0, 255));
        case (p)
            0:
            begin
                lh1 = 8'h55; lh2 = 8'hAA; lmax = 8'd64;
                sm1 = 8'hA5; sm2 = 8'h5A; sver = 8'd1; smax = 16'd128;
            end
            1:
            begin
                lmax = 8'hFF;
                smax = 16'hFFFF;
            end
            2:
            begin
                lmax = 8'd0;
                smax = 16'd0;
            end
            3:
            begin
                // legacy header starts on the second sensor magic byte
                lh1 = sm2;
                lmax = 8'($urandom_range(0, 64));
                smax = 16'($urandom_range(0, 64));
            end
            default:
            begin
                // both headers match, legacy wins
                lh1 = sm1;
                lh2 = sm2;
                lmax = 8'($urandom_range(0, 20));
                smax = 16'($urandom_range(0, 20));
            end
        endcase
        write_reg(REG_LEG_HEAD_FIRST,   {8'($urandom_range(0, 255)), lh1});
        write_reg(REG_LEG_HEAD_SECOND,  {8'($urandom_range(0, 255)), lh2});
        write_reg(REG_LEG_MAX_PAYLOAD,  {8'($urandom_range(0, 255)), lmax});
        write_reg(REG_SEN_MAGIC_FIRST,  {8'($urandom_range(0, 255)), sm1});
        write_reg(REG_SEN_MAGIC_SECOND, {8'($urandom_range(0, 255)), sm2});
        write_reg(REG_SEN_VERSION,      {8'($urandom_range(0, 255)), sver});
        write_reg(REG_SEN_MAX_PAYLOAD,  smax);
        write_reg(REG_SPARE,            16'($urandom_range(0, 65535)));
    endtask

    function automatic script_row_t rx_row(input logic [7:0] b);
        script_row_t r;
        r = '0;
        r.val = {8'h00, b};
        return r;
    endfunction

    function automatic script_row_t chk_row(input logic [7:0] b, input logic [2:0] kind,
                                            input logic last);
        script_row_t r;
        r = rx_row(b);
        r.typed = 1'b1;
        r.exp = '{data: b, kind: kind, first: 1'b0, last: last, run_end: 1'b1};
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [15:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    // ---------------------------------------------------------------- receiver side

    initial
    begin
        int hold_left;
        bit hold_seen;
        out_stall = 1'b0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_bytes.size() == 0)
            begin
                log_mismatch($sformatf("unexpected byte %02h kind %0d", data_byte, byte_kind));
            end
            else
            begin
                want = due_bytes.pop_front();
                check_field("data_byte", data_byte, want.data);
                check_field("byte_kind", 8'(byte_kind), 8'(want.kind));
                check_field("frame_first", 8'(frame_first), 8'(want.first));
                check_field("frame_last", 8'(frame_last), 8'(want.last));
                check_field("run_end", 8'(run_end), 8'(want.run_end));
            end
        end
    end

    // any transfer on any channel resets the stall counter
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        logic [7:0]  burst [$];
        logic [7:0]  vb;
        logic [15:0] slen;
        int          p;
        int          sent;
        int          len;
        int          pick;
        int          cut;
        bit          held;
        bit          paused;
        bit          big_done;

        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_LEG_HEAD_FIRST;
        cfg_data = 16'h0000;
        fail_count = 0;
        idle_pct = 34;
        held = 1'b0;
        paused = 1'b0;
        big_done = 1'b0;

        leg_first = 8'h55;
        leg_second = 8'hAA;
        leg_max = 8'd64;
        sen_first = 8'hA5;
        sen_second = 8'h5A;
        sen_ver = 8'd1;
        sen_max = 16'd128;
        la_buf = '{default: 8'h00};
        la_cnt = 0;
        la_phase = PH_HUNT;
        remain = '0;

        // sensor frame with zero length at reset values, trailer streamed
        script.push_back(rx_row(8'hA5));
        script.push_back(rx_row(8'h5A));
        script.push_back(rx_row(8'h01));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'h00));
        script.push_back(chk_row(8'h80, KIND_SENSOR, 1'b0));
        script.push_back(chk_row(8'h7F, KIND_SENSOR, 1'b0));
        script.push_back(chk_row(8'h01, KIND_SENSOR, 1'b0));
        script.push_back(chk_row(8'hFE, KIND_SENSOR, 1'b1));
        // legacy length above the limit, then unmatched drops
        script.push_back(rx_row(8'h55));
        script.push_back(rx_row(8'hAA));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'hFF));
        // bad sensor version, then a whole legacy frame inside the lookahead
        script.push_back(cfg_row(REG_LEG_HEAD_FIRST, 16'h005A));
        script.push_back(cfg_row(REG_LEG_HEAD_SECOND, 16'h0055));
        script.push_back(rx_row(8'hA5));
        script.push_back(rx_row(8'h5A));
        script.push_back(rx_row(8'h55));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'h77));
        // both headers match: legacy takes it
        script.push_back(cfg_row(REG_LEG_HEAD_FIRST, 16'h00A5));
        script.push_back(cfg_row(REG_LEG_HEAD_SECOND, 16'h005A));
        script.push_back(rx_row(8'hA5));
        script.push_back(rx_row(8'h5A));
        script.push_back(rx_row(8'h00));
        script.push_back(rx_row(8'h00));
        script.push_back(chk_row(8'h33, KIND_LEGACY, 1'b1));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[r])
        begin
            if (script[r].is_cfg)
            begin
                drain();
                write_reg(script[r].idx, script[r].val);
            end
            else
            begin
                send_byte(script[r].val[7:0], script[r].typed, script[r].exp);
            end
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            program_phase(p);
            idle_pct = (p == 0) ? 0 : 34;
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if (p == 1 && sent >= 10 && !held)
                begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if (p == 3 && sent >= 25 && !paused)
                begin
                    drain();
                    paused = 1'b1;
                end
                burst.delete();
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    len = $urandom_range(0, (leg_max < 6) ? leg_max : 6);
                    if ($urandom_range(0, 7) == 0 && leg_max <= 64)
                    begin
                        len = leg_max;
                    end
                    burst = '{leg_first, leg_second, 8'($urandom_range(0, 255)), 8'(len)};
                    repeat (len + 1) burst.push_back(8'($urandom_range(0, 255)));
                end
                else if (pick < 65)
                begin
                    len = $urandom_range(0, (sen_max < 6) ? sen_max : 6);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        if (sen_max >= 300 && !big_done)
                        begin
                            len = $urandom_range(256, 300);
                            big_done = 1'b1;
                        end
                        else if (sen_max <= 64)
                        begin
                            len = sen_max;
                        end
                    end
                    slen = 16'(len);
                    burst = '{sen_first, sen_second, sen_ver, 8'($urandom_range(0, 255)),
                              slen[7:0], slen[15:8]};
                    repeat (len + 4) burst.push_back(8'($urandom_range(0, 255)));
                end
                else if (pick < 75 && leg_max != 8'hFF)
                begin
                    len = $urandom_range(leg_max + 1, 255);
                    burst = '{leg_first, leg_second, 8'($urandom_range(0, 255)), 8'(len)};
                end
                else if (pick < 85)
                begin
                    vb = sen_ver;
                    slen = 16'($urandom_range(0, 6));
                    if (sen_max == 16'hFFFF || $urandom_range(0, 1) == 0)
                    begin
                        vb = sen_ver ^ (8'd1 << $urandom_range(0, 7));
                    end
                    else
                    begin
                        slen = 16'($urandom_range(sen_max + 1, 65535));
                    end
                    burst = '{sen_first, sen_second, vb, 8'($urandom_range(0, 255)),
                              slen[7:0], slen[15:8]};
                end
                else if (pick < 93)
                begin
                    // header cut short, the following bytes land in the lookahead
                    if ($urandom_range(0, 1) == 0)
                    begin
                        burst = '{leg_first, leg_second, 8'h00};
                    end
                    else
                    begin
                        burst = '{sen_first, sen_second, sen_ver};
                    end
                    cut = $urandom_range(1, 3);
                    while (burst.size() > cut)
                    begin
                        void'(burst.pop_back());
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
                end
                foreach (burst[i])
                begin
                    send_byte(burst[i], 1'b0, '0);
                end
                sent += burst.size();
            end
        end

        drain();
        if (due_bytes.size() != 0)
        begin
            log_mismatch($sformatf("%0d predicted bytes never came out", due_bytes.size()));
        end
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
